### hdl/tma_pkg.sv
// Shared types and constants for the trimmed-mean ADC averager.
// Holds the per-channel store layout and the divide-by-constant reciprocal.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tma_pkg;

	// Block configuration
	localparam int CHANNELS = 16;
	localparam int SAMPLES  = 8;

	// Field widths
	localparam int SAMPLE_W = 12;
	localparam int CHAN_W   = 4;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hfff;

	// Store geometry
	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(SAMPLES);
	localparam int SUM_W = $clog2(SAMPLES * 4095 + 1);

	// Divide by SAMPLES-2 as a multiply by a rounded-up reciprocal; exact for any
	// dividend below 2**SUM_W because 2**DIV_L >= DIV.
	localparam int DIV     = SAMPLES - 2;
	localparam int DIV_L   = $clog2(DIV);
	localparam int DIV_SH  = SUM_W + DIV_L;
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << DIV_SH) + 64'(DIV) - 64'd1) / 64'(DIV);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	// One channel's store entry
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] max_val;
		logic [SAMPLE_W-1:0] min_val;
		logic [CNT_W-1:0]    cnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t ENTRY_RST = '{
		sum:     '0,
		max_val: '0,
		min_val: FULL_SCALE,
		cnt:     '0
	};

endpackage

`default_nettype wire

### hdl/trimmed_mean_adc_averager_top.sv
// Top level of the trimmed-mean ADC averager.
// Depends on tma_pkg and tma_ram.
`timescale 1ns / 1ps
`default_nettype none

// Takes one tagged ADC sample per cycle when sample_stall is low, on any mix of
// channels, including the same channel in consecutive cycles. Each channel's
// sum, max, min and count live in one RAM entry that is read on acceptance and
// written back as the item leaves stage 1; the entry just written is forwarded
// to a following item on the same channel. When a channel collects SAMPLES
// samples, the sum less max and min is divided by SAMPLES-2 (truncating) and
// reported with the channel number through stage 2 and the output register.
// The channel store restarts from sum 0, max 0, min 4095. Per-channel valid
// bits make every entry read as cleared after reset, so no clearing pass is
// needed. Samples tagged with a channel at or above CHANNELS are taken and
// dropped.
module trimmed_mean_adc_averager_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic [tma_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [tma_pkg::CHAN_W-1:0]    channel,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic      [tma_pkg::CHAN_W-1:0]    result_channel,
	output logic      [tma_pkg::SAMPLE_W-1:0]  mean_value
);

	import tma_pkg::*;

	// Handshake and addressing
	logic             accept;
	logic             in_range;
	logic [CH_AW-1:0] rd_addr;
	logic [CHANNELS-1:0] vld_q;

	// Stage 1: read-modify-write
	logic                valid_s1;
	logic                fwd_s1;
	logic                hit_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic [CH_AW-1:0]    addr_s1;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              rd_entry;
	entry_t              cur;
	entry_t              nxt;
	entry_t              wb_data;
	entry_t              wb_q;
	logic [CNT_W:0]      cnt_inc;
	logic                done;
	logic [SUM_W-1:0]    sum_new;
	logic [SUM_W-1:0]    rest;
	logic                wr_en;
	logic                s1_go;

	// Stage 2: trimmed sum waiting for the divide
	logic                valid_s2;
	logic [CHAN_W-1:0]   chan_s2;
	logic [SUM_W-1:0]    rest_s2;
	logic                s2_go;

	// Output register
	logic                out_free;
	logic                result_valid_q;
	logic [CHAN_W-1:0]   result_channel_q;
	logic [SAMPLE_W-1:0] mean_value_q;
	logic [PROD_W-1:0]   prod;

	// Flow control: each stage moves when the one after it can take its item
	assign out_free     = !result_valid_q || !result_stall;
	assign s2_go        = !valid_s2 || out_free;
	assign s1_go        = !valid_s1 || !done || s2_go;
	assign sample_stall = !s1_go;
	assign accept       = sample_valid && s1_go;

	assign in_range = 8'(channel) < 8'(CHANNELS);
	assign rd_addr  = CH_AW'(channel);
	assign addr_s1  = CH_AW'(chan_s1);

	// Channel store
	tma_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CHANNELS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wb_data),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// Pick the current entry: forwarded write-back, stored data, or cleared
	always_comb begin
		priority if (fwd_s1) begin
			cur = wb_q;
		end else if (hit_s1) begin
			cur = rd_entry;
		end else begin
			cur = ENTRY_RST;
		end
	end

	// Fold the sample into the entry
	always_comb begin
		sum_new     = cur.sum + SUM_W'(sample_s1);
		cnt_inc     = {1'b0, cur.cnt} + (CNT_W + 1)'(1);
		done        = cnt_inc == (CNT_W + 1)'(SAMPLES);
		nxt.sum     = sum_new;
		nxt.max_val = (sample_s1 > cur.max_val) ? sample_s1 : cur.max_val;
		nxt.min_val = (sample_s1 < cur.min_val) ? sample_s1 : cur.min_val;
		nxt.cnt     = cnt_inc[CNT_W-1:0];
		rest        = sum_new - SUM_W'(nxt.max_val) - SUM_W'(nxt.min_val);
		wb_data     = done ? ENTRY_RST : nxt;
	end

	assign wr_en = valid_s1 && s1_go;

	// Stage 1 control: capture item, forward flag and entry valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			hit_s1   <= 1'b0;
			vld_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= in_range;
				fwd_s1   <= wr_en && (chan_s1 == channel);
				hit_s1   <= in_range ? vld_q[rd_addr] : 1'b0;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				vld_q[addr_s1] <= !done;
			end
		end
	end

	// Stage 1 payload and write-back copy for forwarding
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			chan_s1   <= channel;
		end
		if (wr_en) begin
			wb_q <= wb_data;
		end
	end

	// Stage 2: hold completed windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_go) begin
			valid_s2 <= valid_s1 && done;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			chan_s2 <= chan_s1;
			rest_s2 <= rest;
		end
	end

	// Divide by SAMPLES-2 through the reciprocal
	assign prod = PROD_W'(rest_s2) * PROD_W'(RECIP);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			result_channel_q <= chan_s2;
			mean_value_q     <= SAMPLE_W'(prod >> DIV_SH);
		end
	end

	assign result_valid   = result_valid_q;
	assign result_channel = result_channel_q;
	assign mean_value     = mean_value_q;

endmodule

`default_nettype wire

### hdl/tma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read during a write to the same address returns the old contents.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### bench/trimmed_mean_adc_averager_top_test.sv
// Self-checking bench for the trimmed-mean ADC averager top level.
// Depends on tma_pkg and trimmed_mean_adc_averager_top; drives both handshakes and
// checks every reported mean against a per-channel window model or a fixed directed answer.
`timescale 1ns / 1ps

module trimmed_mean_adc_averager_top_test;

	typedef logic [tma_pkg::SAMPLE_W-1:0] adc_t;
	typedef logic [tma_pkg::CHAN_W-1:0]   chan_t;

	// One reported trimmed mean
	typedef struct packed {
		chan_t chan;
		adc_t  mean;
	} trimmed_mean_t;

	// One directed row: a sample repeated reps times, last one optionally with a fixed answer
	typedef struct packed {
		adc_t       value;
		chan_t      ch;
		logic [3:0] reps;
		bit         typed;
		adc_t       mean;
	} stim_row_t;

	typedef enum int {FLOW, LIGHT, HEAVY, TOGGLE, BLOCKED}          stall_mode_e;
	typedef enum int {ANY_CHAN, TWO_CHAN, ONE_CHAN, RUN_CHAN}       chan_mode_e;
	typedef enum int {FULL_RANGE, RAILS, BAND, FLAT}                level_mode_e;

	localparam int RANDOM_ITEMS = 1326;
	localparam int HOLD_AT      = 400;
	localparam int FLOOD_ITEMS  = 48;
	localparam int HOLD_CYCLES  = 400;
	localparam int PAUSE_AT     = 900;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 4000;

	localparam adc_t FS = tma_pkg::FULL_SCALE;

	// Rails, all-equal windows, a window holding both rails, back-to-back same channel
	localparam stim_row_t DIRECTED [7] = '{
		'{FS,       4'd15, 4'd7, 1'b0, 12'd0},
		'{12'd0,    4'd0,  4'd3, 1'b0, 12'd0},
		'{FS,       4'd15, 4'd1, 1'b1, FS},
		'{12'd0,    4'd0,  4'd5, 1'b1, 12'd0},
		'{12'd0,    4'd7,  4'd1, 1'b0, 12'd0},
		'{FS,       4'd7,  4'd1, 1'b0, 12'd0},
		'{12'd2048, 4'd7,  4'd6, 1'b1, 12'd2048}
	};

	logic  clk;
	logic  arst_n;
	logic  sample_valid;
	logic  sample_stall;
	adc_t  sample;
	chan_t channel;
	logic  result_valid;
	logic  result_stall;
	chan_t result_channel;
	adc_t  mean_value;

	// Fixed answer travelling with the offered item
	bit   drive_typed;
	adc_t drive_mean;

	// Long receiver hold-off request
	bit hold_req;

	// Per-channel window model
	logic [tma_pkg::SUM_W-1:0] win_sum [tma_pkg::CHANNELS];
	adc_t                      win_max [tma_pkg::CHANNELS];
	adc_t                      win_min [tma_pkg::CHANNELS];
	int unsigned               win_cnt [tma_pkg::CHANNELS];

	trimmed_mean_t pending_means [$];

	int errors;
	int samples_taken;
	int means_checked;
	int held_cycles;

	trimmed_mean_adc_averager_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.channel        (channel),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_channel (result_channel),
		.mean_value     (mean_value)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Fold one sample into its channel window; report the trimmed mean when the window closes
	function automatic bit fold_sample(input adc_t s, input chan_t ch, output trimmed_mean_t r);
		int unsigned trimmed;
		r = '0;
		if (int'(ch) >= tma_pkg::CHANNELS)
			return 1'b0;
		if (s > win_max[ch])
			win_max[ch] = s;
		if (s < win_min[ch])
			win_min[ch] = s;
		win_sum[ch] += tma_pkg::SUM_W'(s);
		win_cnt[ch]++;
		if (win_cnt[ch] < tma_pkg::SAMPLES)
			return 1'b0;
		trimmed = int'(win_sum[ch]) - int'(win_max[ch]) - int'(win_min[ch]);
		trimmed = trimmed / (tma_pkg::SAMPLES - 2);
		if (trimmed > int'(FS))
			trimmed = 32'(FS);
		r.chan = ch;
		r.mean = adc_t'(trimmed);
		win_sum[ch] = '0;
		win_max[ch] = '0;
		win_min[ch] = FS;
		win_cnt[ch] = 0;
		return 1'b1;
	endfunction

	// Offer one item and return at the edge that takes it
	task automatic offer_sample(input adc_t s, input chan_t ch, input bit typed, input adc_t mean);
		sample_valid <= 1'b1;
		sample       <= s;
		channel      <= ch;
		drive_typed  <= typed;
		drive_mean   <= mean;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	// Predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		trimmed_mean_t want;
		bit            closes;
		if (arst_n && sample_valid && !sample_stall) begin
			samples_taken++;
			closes = fold_sample(sample, channel, want);
			if (drive_typed)
				pending_means.push_back('{chan: channel, mean: drive_mean});
			else if (closes)
				pending_means.push_back(want);
		end
		if (arst_n && sample_valid && sample_stall)
			held_cycles++;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_means.size() == 0) begin
				$error("unexpected mean %0d on channel %0d", mean_value, result_channel);
				errors++;
			end else begin
				want = pending_means.pop_front();
				means_checked++;
				if (result_channel !== want.chan) begin
					$error("result_channel: expected %0d, got %0d", want.chan, result_channel);
					errors++;
				end
				if (mean_value !== want.mean) begin
					$error("mean_value: expected %0d, got %0d", want.mean, mean_value);
					errors++;
				end
			end
		end
	end

	// Receiver: stall on random phases, or hold off for a long stretch on request
	initial begin
		stall_mode_e mode;
		int          span;
		result_stall = 1'b0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = stall_mode_e'($urandom_range(0, 4));
				span = $urandom_range(1, 60);
				while (span > 0 && !hold_req) begin
					case (mode)
						FLOW:    result_stall <= 1'b0;
						LIGHT:   result_stall <= ($urandom_range(0, 3) == 0);
						HEAVY:   result_stall <= ($urandom_range(0, 3) != 0);
						TOGGLE:  result_stall <= ~result_stall;
						default: result_stall <= 1'b1;
					endcase
					@(posedge clk);
					span--;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle = 0;
			else
				idle++;
		end
		$display("[trimmed_mean_adc_averager_top] ERROR");
		$finish;
	end

	// Sender: directed table, then bursts of random items
	initial begin
		chan_mode_e  chan_mode;
		level_mode_e level_mode;
		chan_t       hot_a;
		chan_t       hot_b;
		chan_t       ch;
		adc_t        s;
		adc_t        flat_level;
		int          center;
		int          v;
		int          seg_left;
		int          burst_left;
		int          flood_left;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		channel      = '0;
		drive_typed  = 1'b0;
		drive_mean   = '0;
		hold_req     = 1'b0;
		errors       = 0;
		for (int c = 0; c < tma_pkg::CHANNELS; c++) begin
			win_sum[c] = '0;
			win_max[c] = '0;
			win_min[c] = FS;
			win_cnt[c] = 0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, with an occasional gap between rows
		foreach (DIRECTED[r]) begin
			for (int k = 0; k < DIRECTED[r].reps; k++)
				offer_sample(DIRECTED[r].value, DIRECTED[r].ch,
					DIRECTED[r].typed && (k == DIRECTED[r].reps - 1), DIRECTED[r].mean);
			if ($urandom_range(0, 1)) begin
				sample_valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end

		seg_left   = 0;
		burst_left = $urandom_range(1, 40);
		flood_left = 0;
		ch         = '0;
		hot_a      = '0;
		hot_b      = '0;
		center     = 0;
		flat_level = '0;
		chan_mode  = ANY_CHAN;
		level_mode = FULL_RANGE;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Pause until every pending mean has come back; advance the clock first so the
			// last accepted item is already predicted
			if (i == PAUSE_AT) begin
				sample_valid <= 1'b0;
				@(posedge clk);
				while (pending_means.size() != 0)
					@(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			// Long receiver hold-off while one channel is flooded back to back
			if (i == HOLD_AT) begin
				hold_req   = 1'b1;
				flood_left = FLOOD_ITEMS;
			end

			// Pick the shape of the next segment
			if (seg_left == 0) begin
				seg_left   = $urandom_range(8, 64);
				chan_mode  = chan_mode_e'($urandom_range(0, 3));
				level_mode = level_mode_e'($urandom_range(0, 3));
				hot_a      = chan_t'($urandom);
				hot_b      = chan_t'($urandom);
				center     = $urandom_range(0, int'(FS));
				flat_level = adc_t'($urandom);
			end
			seg_left--;

			if (flood_left > 0)
				ch = hot_a;
			else begin
				case (chan_mode)
					ANY_CHAN: ch = chan_t'($urandom);
					TWO_CHAN: ch = $urandom_range(0, 1) ? hot_a : hot_b;
					ONE_CHAN: ch = hot_a;
					default:  ch = ($urandom_range(0, 3) == 0) ? chan_t'($urandom) : ch;
				endcase
			end

			case (level_mode)
				FULL_RANGE: s = adc_t'($urandom);
				RAILS:      s = $urandom_range(0, 1) ? FS : adc_t'(0);
				BAND: begin
					v = center + int'($urandom_range(0, 64)) - 32;
					if (v < 0)
						v = 0;
					if (v > int'(FS))
						v = int'(FS);
					s = adc_t'(v);
				end
				default:    s = flat_level;
			endcase

			offer_sample(s, ch, 1'b0, '0);

			// Keep the flood dense; otherwise close bursts with a random gap
			if (flood_left > 0)
				flood_left--;
			else if (burst_left == 0) begin
				sample_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 40);
			end else
				burst_left--;
		end
		sample_valid <= 1'b0;

		// Drain what is still in flight
		@(posedge clk);
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d samples taken, %0d trimmed means checked, %0d errors",
			samples_taken, means_checked, errors);
		$display("Input held back for %0d cycles under output back-pressure", held_cycles);
		if (errors == 0)
			$display("[trimmed_mean_adc_averager_top] OK");
		else
			$display("[trimmed_mean_adc_averager_top] ERROR");
		$finish;
	end

endmodule
